/* src/fcm_pkg.sv */
// Shared types, constants and the output scaling for the force calibration matrix.
`default_nettype none

package fcm_pkg;

    localparam int NUM_AXES     = 3;
    localparam int NUM_CHANNELS = 6;
    localparam int ADC_INPUTS   = 6;
    localparam int OUT_AXES     = 3;

    localparam int COEF_W  = 24;
    localparam int ADC_W   = 24;
    localparam int PROD_W  = COEF_W + ADC_W;
    localparam int ACC_W   = PROD_W + $clog2(NUM_CHANNELS + 1);
    localparam int FORCE_W = 40;
    localparam int SHIFT   = 11;
    localparam int DIV_BIAS = (1 << SHIFT) - 1;

    localparam int DEPTH  = NUM_AXES * NUM_CHANNELS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int AXIS_W = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
    localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_FINISH
    } fcm_state_t;

    // Divide by 2^SHIFT, truncating toward zero.
    function automatic logic signed [FORCE_W-1:0] div_scale(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] biased;
        logic signed [ACC_W-1:0] shifted;
        biased  = v + (v[ACC_W-1] ? ACC_W'(DIV_BIAS) : {ACC_W{1'b0}});
        shifted = biased >>> SHIFT;
        return shifted[FORCE_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* src/force_calibration_matrix.sv */
// Force calibration matrix: coefficient store, multiply-accumulate sequencer, result register.
// A load transfer writes one coefficient and gives no result; loads with an axis or column
// outside the matrix are dropped. A sample transfer with a nonzero status byte goes straight
// to the finish step, which loads an error result and frees the input together. A good
// sample steps through the 3 x 6 coefficient memory one entry per cycle through its single
// read port and one 24 x 24 multiplier and then drains the product pipeline; the finish step
// loads the result and frees the input together, so the next transfer can be taken as soon as
// the result is valid. The store reads as zero after reset through per-entry valid flags; no
// clearing pass is needed. A finished result sits in the output register while the next item
// is taken; a sample only waits at its end if that register is still held.
`default_nettype none

module force_calibration_matrix (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic                                 command,
    input  wire logic [1:0]                           axis,
    input  wire logic [2:0]                           column,
    input  wire logic signed [fcm_pkg::COEF_W-1:0]    coefficient,
    input  wire logic [7:0]                           frame_status,
    input  wire logic signed [fcm_pkg::ADC_W-1:0]     adc0,
    input  wire logic signed [fcm_pkg::ADC_W-1:0]     adc1,
    input  wire logic signed [fcm_pkg::ADC_W-1:0]     adc2,
    input  wire logic signed [fcm_pkg::ADC_W-1:0]     adc3,
    input  wire logic signed [fcm_pkg::ADC_W-1:0]     adc4,
    input  wire logic signed [fcm_pkg::ADC_W-1:0]     adc5,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic signed [fcm_pkg::FORCE_W-1:0]       force_x,
    output logic signed [fcm_pkg::FORCE_W-1:0]       force_y,
    output logic signed [fcm_pkg::FORCE_W-1:0]       force_z,
    output logic                                      sensor_error
);

    localparam int ADDR_W = fcm_pkg::ADDR_W;
    localparam int AXIS_W = fcm_pkg::AXIS_W;
    localparam int CH_W   = fcm_pkg::CH_W;

    fcm_pkg::fcm_state_t state_reg, state_next;

    // coefficient memory and per-entry written flags
    logic signed [fcm_pkg::COEF_W-1:0] mem [fcm_pkg::DEPTH];
    logic signed [fcm_pkg::COEF_W-1:0] mem_q_reg;
    logic [fcm_pkg::DEPTH-1:0]         written_reg;

    logic                  in_xfer;
    logic                  load_ok;
    logic                  wr_en;
    logic [ADDR_W-1:0]     ld_addr;

    // sequencer
    logic                  issue_en;
    logic                  issue_last;
    logic [ADDR_W-1:0]     rd_addr_reg;
    logic [AXIS_W-1:0]     ax_cnt_reg;
    logic [CH_W-1:0]       ch_cnt_reg;

    // stage 1: memory data
    logic                  s1_vld_reg;
    logic                  s1_hit_reg;
    logic [AXIS_W-1:0]     s1_ax_reg;
    logic [CH_W-1:0]       s1_ch_reg;
    logic                  s1_last_reg;
    logic signed [fcm_pkg::COEF_W-1:0] s1_coef;
    logic signed [fcm_pkg::ADC_W-1:0]  s1_reading;

    // stage 2: product
    logic                  s2_vld_reg;
    logic [AXIS_W-1:0]     s2_ax_reg;
    logic [CH_W-1:0]       s2_ch_reg;
    logic                  s2_last_reg;
    logic signed [fcm_pkg::PROD_W-1:0] prod_reg;

    logic signed [fcm_pkg::ACC_W-1:0]  acc_reg;
    logic signed [fcm_pkg::ACC_W-1:0]  acc_sum;
    logic signed [fcm_pkg::ACC_W-1:0]  sum_reg [fcm_pkg::NUM_AXES];

    logic signed [fcm_pkg::ADC_W-1:0]  adc_reg [fcm_pkg::ADC_INPUTS];
    logic                  err_reg;

    logic                  out_free;
    logic                  out_load;
    logic                  out_valid_reg;
    logic signed [fcm_pkg::FORCE_W-1:0] force_reg [fcm_pkg::OUT_AXES];
    logic                  sensor_error_reg;

    assign in_xfer  = in_valid && !in_stall;
    assign load_ok  = (32'(axis) < fcm_pkg::NUM_AXES) && (32'(column) < fcm_pkg::NUM_CHANNELS);
    assign wr_en    = in_xfer && (command == fcm_pkg::CMD_LOAD) && load_ok;
    assign ld_addr  = ADDR_W'(ADDR_W'(axis) * ADDR_W'(fcm_pkg::NUM_CHANNELS) + ADDR_W'(column));
    assign out_free = !out_valid_reg || !out_stall;
    assign issue_last = (ax_cnt_reg == AXIS_W'(fcm_pkg::NUM_AXES - 1)) &&
                        (ch_cnt_reg == CH_W'(fcm_pkg::NUM_CHANNELS - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fcm_pkg::ST_IDLE:
            begin
                if (in_xfer && (command == fcm_pkg::CMD_SAMPLE))
                begin
                    if (frame_status != 8'h00)
                        state_next = fcm_pkg::ST_FINISH;
                    else
                        state_next = fcm_pkg::ST_ISSUE;
                end
            end
            fcm_pkg::ST_ISSUE:
            begin
                if (issue_last)
                    state_next = fcm_pkg::ST_DRAIN;
            end
            fcm_pkg::ST_DRAIN:
            begin
                if (s2_vld_reg && s2_last_reg)
                    state_next = fcm_pkg::ST_FINISH;
            end
            fcm_pkg::ST_FINISH:
            begin
                if (out_free)
                    state_next = fcm_pkg::ST_IDLE;
            end
            default: state_next = fcm_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        in_stall = 1'b1;
        issue_en = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            fcm_pkg::ST_IDLE:   in_stall = 1'b0;
            fcm_pkg::ST_ISSUE:  issue_en = 1'b1;
            fcm_pkg::ST_DRAIN:  issue_en = 1'b0;
            fcm_pkg::ST_FINISH: out_load = out_free;
            default:            in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= fcm_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // memory: one write port for loads, one registered read port for the sequencer
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[ld_addr] <= coefficient;
        mem_q_reg <= mem[rd_addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            written_reg <= '0;
        else if (wr_en)
            written_reg[ld_addr] <= 1'b1;
    end

    // read sequencer and pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_addr_reg <= '0;
            ax_cnt_reg  <= '0;
            ch_cnt_reg  <= '0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= issue_en;
            s2_vld_reg <= s1_vld_reg;
            if (in_xfer)
            begin
                rd_addr_reg <= '0;
                ax_cnt_reg  <= '0;
                ch_cnt_reg  <= '0;
            end
            else if (issue_en)
            begin
                rd_addr_reg <= rd_addr_reg + ADDR_W'(1);
                if (ch_cnt_reg == CH_W'(fcm_pkg::NUM_CHANNELS - 1))
                begin
                    ch_cnt_reg <= '0;
                    ax_cnt_reg <= ax_cnt_reg + AXIS_W'(1);
                end
                else
                begin
                    ch_cnt_reg <= ch_cnt_reg + CH_W'(1);
                end
            end
        end
    end

    // unwritten entries read as zero
    assign s1_coef = s1_hit_reg ? mem_q_reg : '0;

    always_comb
    begin
        s1_reading = '0;
        for (int i = 0; i < fcm_pkg::ADC_INPUTS; i++)
        begin
            if (s1_ch_reg == CH_W'(i))
                s1_reading = adc_reg[i];
        end
    end

    assign acc_sum = ((s2_ch_reg == '0) ? {fcm_pkg::ACC_W{1'b0}} : acc_reg) +
                     fcm_pkg::ACC_W'(prod_reg);

    // datapath
    always_ff @(posedge clk)
    begin
        if (in_xfer && (command == fcm_pkg::CMD_SAMPLE))
        begin
            adc_reg[0] <= adc0;
            adc_reg[1] <= adc1;
            adc_reg[2] <= adc2;
            adc_reg[3] <= adc3;
            adc_reg[4] <= adc4;
            adc_reg[5] <= adc5;
            err_reg    <= (frame_status != 8'h00);
        end

        s1_hit_reg  <= written_reg[rd_addr_reg];
        s1_ax_reg   <= ax_cnt_reg;
        s1_ch_reg   <= ch_cnt_reg;
        s1_last_reg <= issue_last;

        prod_reg    <= s1_coef * s1_reading;
        s2_ax_reg   <= s1_ax_reg;
        s2_ch_reg   <= s1_ch_reg;
        s2_last_reg <= s1_last_reg;

        if (s2_vld_reg)
        begin
            if (s2_ch_reg == CH_W'(fcm_pkg::NUM_CHANNELS - 1))
                sum_reg[s2_ax_reg] <= acc_sum;
            else
                acc_reg <= acc_sum;
        end

        if (out_load)
        begin
            for (int a = 0; a < fcm_pkg::OUT_AXES; a++)
            begin
                if (err_reg || (a >= fcm_pkg::NUM_AXES))
                    force_reg[a] <= '0;
                else
                    force_reg[a] <= fcm_pkg::div_scale(sum_reg[a]);
            end
            sensor_error_reg <= err_reg;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    assign out_valid    = out_valid_reg;
    assign force_x      = force_reg[0];
    assign force_y      = force_reg[1];
    assign force_z      = force_reg[2];
    assign sensor_error = sensor_error_reg;

    // products only flow while a frame is being worked
    a_pipe_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        s2_vld_reg |-> (state_reg == fcm_pkg::ST_ISSUE || state_reg == fcm_pkg::ST_DRAIN))
        else $error("product stage active outside a frame");

    // pipeline is empty when the result is formed
    a_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fcm_pkg::ST_FINISH) |-> (!s1_vld_reg && !s2_vld_reg))
        else $error("result formed before pipeline drained");

    // a new result only comes out of the finish step
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == fcm_pkg::ST_FINISH))
        else $error("result raised outside finish step");

    // error results carry zero forces
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && sensor_error_reg) |->
            (force_reg[0] == '0 && force_reg[1] == '0 && force_reg[2] == '0))
        else $error("error result with nonzero force");

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the force calibration matrix: queued stimulus, driver, monitor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int      RANDOM_ITEMS = 1800;
    localparam int      CYCLE_LIMIT  = 1000000;
    localparam int      DRAIN_CYCLES = 30;
    localparam longint  FORCE_SCALE  = 2048;

    typedef struct {
        logic                                              command;
        logic [1:0]                                        axis;
        logic [2:0]                                        column;
        logic [fcm_pkg::COEF_W-1:0]                        coefficient;
        logic [7:0]                                        frame_status;
        logic [fcm_pkg::ADC_INPUTS-1:0][fcm_pkg::ADC_W-1:0] adc;
        int                                                gap;
        bit                                                hold_for_drain;
    } frame_item_t;

    typedef struct {
        logic [fcm_pkg::OUT_AXES-1:0][fcm_pkg::FORCE_W-1:0] axis_force;
        logic                                              err;
    } force_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                                in_valid = 1'b0;
    logic                                in_stall;
    logic                                command = fcm_pkg::CMD_LOAD;
    logic [1:0]                          axis = '0;
    logic [2:0]                          column = '0;
    logic signed [fcm_pkg::COEF_W-1:0]   coefficient = '0;
    logic [7:0]                          frame_status = '0;
    logic signed [fcm_pkg::ADC_W-1:0]    adc0 = '0;
    logic signed [fcm_pkg::ADC_W-1:0]    adc1 = '0;
    logic signed [fcm_pkg::ADC_W-1:0]    adc2 = '0;
    logic signed [fcm_pkg::ADC_W-1:0]    adc3 = '0;
    logic signed [fcm_pkg::ADC_W-1:0]    adc4 = '0;
    logic signed [fcm_pkg::ADC_W-1:0]    adc5 = '0;
    logic                                out_valid;
    logic                                out_stall = 1'b0;
    logic signed [fcm_pkg::FORCE_W-1:0]  force_x;
    logic signed [fcm_pkg::FORCE_W-1:0]  force_y;
    logic signed [fcm_pkg::FORCE_W-1:0]  force_z;
    logic                                sensor_error;

    force_calibration_matrix uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .axis         (axis),
        .column       (column),
        .coefficient  (coefficient),
        .frame_status (frame_status),
        .adc0         (adc0),
        .adc1         (adc1),
        .adc2         (adc2),
        .adc3         (adc3),
        .adc4         (adc4),
        .adc5         (adc5),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .force_x      (force_x),
        .force_y      (force_y),
        .force_z      (force_z),
        .sensor_error (sensor_error)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Shadow copy of the coefficient store, updated in transfer order
    logic signed [fcm_pkg::COEF_W-1:0] calib_coef [fcm_pkg::NUM_AXES][fcm_pkg::NUM_CHANNELS];

    frame_item_t   pending_items[$];
    force_result_t expected_forces[$];
    frame_item_t   cur_item;

    string axis_names [fcm_pkg::OUT_AXES] = '{"force_x", "force_y", "force_z"};

    int  mismatches    = 0;
    int  loads_sent    = 0;
    int  samples_sent  = 0;
    int  fault_frames  = 0;
    int  results_seen  = 0;
    int  cycle_count   = 0;
    int  idle_since    = 0;
    int  stall_left    = 0;
    int  stall_quiet   = 0;
    int  items_queued  = 0;
    bit  tx_burst      = 1'b0;
    int  tx_segment    = 0;

    // Mostly short, occasionally long idle stretch
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Full-scale values and values near zero show up more often than pure chance gives
    function automatic logic [23:0] rand24();
        int r;
        logic [23:0] v;
        r = $urandom_range(0, 9);
        if (r == 0)
            v = 24'h800000;
        else if (r == 1)
            v = 24'h7FFFFF;
        else if (r == 2)
        begin
            v = 24'($urandom_range(0, 15));
            if ($urandom_range(0, 1) == 1)
                v = -v;
        end
        else
            v = 24'($urandom);
        return v;
    endfunction

    // Every field random; callers override what the command uses
    function automatic frame_item_t noise_item();
        frame_item_t it;
        it.command        = 1'($urandom);
        it.axis           = 2'($urandom);
        it.column         = 3'($urandom);
        it.coefficient    = 24'($urandom);
        it.frame_status   = 8'($urandom);
        for (int c = 0; c < fcm_pkg::ADC_INPUTS; c++)
            it.adc[c] = 24'($urandom);
        it.gap            = 0;
        it.hold_for_drain = 1'b0;
        return it;
    endfunction

    function automatic frame_item_t load_item(logic [1:0] ax, logic [2:0] col, logic [23:0] k);
        frame_item_t it;
        it             = noise_item();
        it.command     = fcm_pkg::CMD_LOAD;
        it.axis        = ax;
        it.column      = col;
        it.coefficient = k;
        return it;
    endfunction

    function automatic frame_item_t sample_item(logic [7:0] st);
        frame_item_t it;
        it              = noise_item();
        it.command      = fcm_pkg::CMD_SAMPLE;
        it.frame_status = st;
        for (int c = 0; c < fcm_pkg::ADC_INPUTS; c++)
            it.adc[c] = rand24();
        return it;
    endfunction

    task automatic enqueue(input frame_item_t it);
        if (tx_segment == 0)
        begin
            tx_burst   = ($urandom_range(0, 2) == 0);
            tx_segment = $urandom_range(20, 150);
        end
        tx_segment--;
        it.gap = tx_burst ? 0 : idle_length();
        pending_items.push_back(it);
        items_queued++;
    endtask

    // Predict the effect of one accepted transfer
    task automatic apply_item(input frame_item_t it);
        force_result_t r;
        longint        acc;
        longint        quot;
        longint        reading;
        if (it.command == fcm_pkg::CMD_LOAD)
        begin
            loads_sent++;
            if (it.axis < fcm_pkg::NUM_AXES && it.column < fcm_pkg::NUM_CHANNELS)
                calib_coef[it.axis][it.column] = it.coefficient;
        end
        else
        begin
            samples_sent++;
            r.axis_force = '0;
            r.err        = (it.frame_status != 8'h00);
            if (r.err)
                fault_frames++;
            else
            begin
                for (int a = 0; a < fcm_pkg::OUT_AXES; a++)
                begin
                    acc = 0;
                    if (a < fcm_pkg::NUM_AXES)
                    begin
                        for (int c = 0; c < fcm_pkg::NUM_CHANNELS; c++)
                        begin
                            // channels without a converter input read as zero
                            reading = (c < fcm_pkg::ADC_INPUTS) ?
                                      longint'($signed(it.adc[c])) : 0;
                            acc += longint'(calib_coef[a][c]) * reading;
                        end
                    end
                    quot = acc / FORCE_SCALE;
                    r.axis_force[a] = quot[fcm_pkg::FORCE_W-1:0];
                end
            end
            expected_forces.push_back(r);
        end
    endtask

    // Driver
    always @(posedge clk or negedge rst_n)
    begin
        bit taken;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            taken = in_valid && !in_stall;
            if (taken)
            begin
                apply_item(cur_item);
                idle_since = 0;
            end
            if (in_valid && !taken)
            begin
                // stalled: payload held
            end
            else if (pending_items.size() != 0 && idle_since >= pending_items[0].gap &&
                     (!pending_items[0].hold_for_drain || expected_forces.size() == 0))
            begin
                cur_item     = pending_items.pop_front();
                in_valid     <= 1'b1;
                command      <= cur_item.command;
                axis         <= cur_item.axis;
                column       <= cur_item.column;
                coefficient  <= cur_item.coefficient;
                frame_status <= cur_item.frame_status;
                adc0         <= cur_item.adc[0];
                adc1         <= cur_item.adc[1];
                adc2         <= cur_item.adc[2];
                adc3         <= cur_item.adc[3];
                adc4         <= cur_item.adc[4];
                adc5         <= cur_item.adc[5];
            end
            else
            begin
                in_valid <= 1'b0;
                idle_since++;
            end
        end
    end

    // Monitor and result-side stall
    always @(posedge clk or negedge rst_n)
    begin
        force_result_t                      want;
        logic signed [fcm_pkg::FORCE_W-1:0] got [fcm_pkg::OUT_AXES];
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_forces.size() == 0)
                begin
                    $error("result transfer with no expected result waiting");
                    mismatches++;
                end
                else
                begin
                    want = expected_forces.pop_front();
                    got  = '{force_x, force_y, force_z};
                    for (int a = 0; a < fcm_pkg::OUT_AXES; a++)
                    begin
                        if (got[a] !== want.axis_force[a])
                        begin
                            $error("%s mismatch: expected %0d, actual %0d", axis_names[a],
                                   $signed(want.axis_force[a]), got[a]);
                            mismatches++;
                        end
                    end
                    if (sensor_error !== want.err)
                    begin
                        $error("sensor_error mismatch: expected %0d, actual %0d",
                               want.err, sensor_error);
                        mismatches++;
                    end
                end
            end

            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                if (stall_quiet > 0)
                    stall_quiet--;
                else if ($urandom_range(0, 3) == 0)
                    stall_left = idle_length();
                if ($urandom_range(0, 199) == 0)
                    stall_quiet = $urandom_range(50, 300);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $error("timeout after %0d cycles, %0d results outstanding",
                   cycle_count, expected_forces.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        frame_item_t it;
        int          r;

        for (int a = 0; a < fcm_pkg::NUM_AXES; a++)
            for (int c = 0; c < fcm_pkg::NUM_CHANNELS; c++)
                calib_coef[a][c] = '0;

        // Directed: cleared store, error frames, extremes, dropped loads
        it = sample_item(8'h00);
        it.adc = '0;
        enqueue(it);
        enqueue(sample_item(8'h00));
        enqueue(load_item(2'd0, 3'd0, 24'h800000));
        enqueue(load_item(2'd0, 3'd5, 24'h7FFFFF));
        enqueue(load_item(2'd1, 3'd5, 24'h7FFFFF));
        enqueue(load_item(2'd2, 3'd3, 24'h800000));
        enqueue(load_item(2'd2, 3'd0, 24'h000001));
        enqueue(load_item(2'd3, 3'd0, 24'h7FFFFF));   // axis outside matrix
        enqueue(load_item(2'd0, 3'd6, 24'h123456));   // column outside matrix
        enqueue(load_item(2'd2, 3'd7, 24'h800000));
        it = sample_item(8'h00);
        it.adc = {fcm_pkg::ADC_INPUTS{24'h800000}};
        enqueue(it);
        it = sample_item(8'h00);
        it.adc = {fcm_pkg::ADC_INPUTS{24'h7FFFFF}};
        enqueue(it);
        it = sample_item(8'h00);
        it.adc = {fcm_pkg::ADC_INPUTS{24'hFFFFFF}};   // readings of -1: truncation toward zero
        enqueue(it);
        it = sample_item(8'hFF);
        it.adc = {fcm_pkg::ADC_INPUTS{24'h7FFFFF}};
        enqueue(it);
        enqueue(sample_item(8'h01));
        enqueue(sample_item(8'h80));
        it = sample_item(8'h00);
        it.hold_for_drain = 1'b1;
        enqueue(it);
        enqueue(sample_item(8'h00));

        // Random: bursts of full reloads, single loads and sample frames
        while (items_queued < RANDOM_ITEMS + 18)
        begin
            r = $urandom_range(0, 99);
            if (r < 4)
            begin
                for (int a = 0; a < fcm_pkg::NUM_AXES; a++)
                    for (int c = 0; c < fcm_pkg::NUM_CHANNELS; c++)
                        enqueue(load_item(2'(a), 3'(c), rand24()));
            end
            else if (r < 40)
            begin
                it = load_item(($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2)),
                               ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                                           : 3'($urandom_range(0, 5)),
                               rand24());
                enqueue(it);
            end
            else
            begin
                it = sample_item(($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255))
                                                              : 8'h00);
                it.hold_for_drain = (items_queued % 400 == 200);
                enqueue(it);
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || in_valid || expected_forces.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_forces.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_forces.size());
            mismatches++;
        end

        $display("Run covered %0d coefficient loads and %0d sample frames (%0d with bad status),",
                 loads_sent, samples_sent, fault_frames);
        $display("%0d force results checked, %0d mismatches, %0d cycles.",
                 results_seen, mismatches, cycle_count);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
